/* rtl/core/lmrp_pkg.sv */
// Shared types and constants for the log metadata record parser.
`timescale 1ns / 1ps

package lmrp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_LOG_TEXT   = 2'd0;
  localparam logic [1:0] KIND_FILE_TEXT  = 2'd1;
  localparam logic [1:0] KIND_LOG_REC    = 2'd2;
  localparam logic [1:0] KIND_FILE_REC   = 2'd3;

  // Input item kinds
  localparam logic ITEM_DATA    = 1'b0;
  localparam logic ITEM_RESTART = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOG_START  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOG_END    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILE_START = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILE_END   = 2'd3;

  // Token reset values
  localparam logic [15:0] RST_LOG_START  = 16'd1;
  localparam logic [15:0] RST_LOG_END    = 16'd2;
  localparam logic [15:0] RST_FILE_START = 16'd3;
  localparam logic [15:0] RST_FILE_END   = 16'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  text;
    logic [31:0] hash;
    logic [15:0] line;
  } lmrp_result_t;

  // Everything one input byte produces: one or two results
  typedef struct packed {
    lmrp_result_t first;
    lmrp_result_t second;
    logic         has_second;
  } lmrp_bundle_t;

  function automatic lmrp_result_t make_result(logic [1:0] kind, logic [7:0] text,
                                               logic [31:0] hash, logic [15:0] line);
    lmrp_result_t r;
    r.kind = kind;
    r.text = text;
    r.hash = hash;
    r.line = line;
    return r;
  endfunction

endpackage

/* rtl/core/lmrp_front.sv */
// Front end: token/config registers and the byte-wise parse state machine.
`timescale 1ns / 1ps

module lmrp_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [lmrp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                      cfg_data,
  input  logic                             accept,
  input  logic                             kind,
  input  logic [7:0]                       data_byte,
  output logic                             push,
  output lmrp_pkg::lmrp_bundle_t           bundle
);

  localparam logic [3:0] ST_BEGIN      = 4'd0;
  localparam logic [3:0] ST_LOG_BEGIN  = 4'd1;
  localparam logic [3:0] ST_LOG_STRING = 4'd2;
  localparam logic [3:0] ST_LOG_LINE   = 4'd3;
  localparam logic [3:0] ST_LOG_HASH   = 4'd4;
  localparam logic [3:0] ST_LOG_END    = 4'd5;
  localparam logic [3:0] ST_FILE_BEGIN = 4'd6;
  localparam logic [3:0] ST_FILE_NAME  = 4'd7;
  localparam logic [3:0] ST_FILE_HASH  = 4'd8;
  localparam logic [3:0] ST_FILE_END   = 4'd9;

  logic [15:0] log_start_token, log_end_token, file_start_token, file_end_token;

  logic [3:0]  parse_state, parse_state_next;
  logic        forward_dir, forward_dir_next;
  logic [1:0]  byte_offset, byte_offset_next;
  logic        pad_phase, pad_phase_next;
  logic [31:0] word_acc, word_acc_next;
  logic [1:0]  word_cnt, word_cnt_next;
  logic [31:0] log_hash, log_hash_next;
  logic [15:0] log_line, log_line_next;
  logic [31:0] file_hash, file_hash_next;

  // Word assembly helpers
  logic [31:0] word_or;
  logic        done2, done4;
  logic        hit_ls, hit_le, hit_fs, hit_fe, hit_any;
  logic [3:0]  open_state;
  logic        open_fwd;
  logic [3:0]  st;
  logic        skip;
  logic [1:0]  offn;
  logic [1:0]  n_res;

  always_comb begin
    unique case (word_cnt)
      2'd0: word_or = word_acc | {24'h0, data_byte};
      2'd1: word_or = word_acc | {16'h0, data_byte, 8'h0};
      2'd2: word_or = word_acc | {8'h0, data_byte, 16'h0};
      2'd3: word_or = word_acc | {data_byte, 24'h0};
      default: word_or = word_acc;
    endcase
  end

  assign done2 = (word_cnt != 2'd0);
  assign done4 = (word_cnt == 2'd3);

  assign hit_ls  = (word_or == {16'h0, log_start_token});
  assign hit_le  = (word_or == {16'h0, log_end_token});
  assign hit_fs  = (word_or == {16'h0, file_start_token});
  assign hit_fe  = (word_or == {16'h0, file_end_token});
  assign hit_any = hit_ls | hit_le | hit_fs | hit_fe;

  // First matching token wins
  always_comb begin
    priority if (hit_ls) begin
      open_state = ST_LOG_BEGIN;
      open_fwd   = 1'b1;
    end else if (hit_le) begin
      open_state = ST_LOG_BEGIN;
      open_fwd   = 1'b0;
    end else if (hit_fs) begin
      open_state = ST_FILE_BEGIN;
      open_fwd   = 1'b1;
    end else begin
      open_state = ST_FILE_BEGIN;
      open_fwd   = 1'b0;
    end
  end

  always_comb begin
    parse_state_next = parse_state;
    forward_dir_next = forward_dir;
    byte_offset_next = byte_offset;
    pad_phase_next   = pad_phase;
    word_acc_next    = word_acc;
    word_cnt_next    = word_cnt;
    log_hash_next    = log_hash;
    log_line_next    = log_line;
    file_hash_next   = file_hash;
    n_res            = 2'd0;
    bundle.first     = lmrp_pkg::make_result(lmrp_pkg::KIND_LOG_TEXT, 8'h0, 32'h0, 16'h0);
    bundle.second    = lmrp_pkg::make_result(lmrp_pkg::KIND_LOG_REC, 8'h0, log_hash, log_line);
    bundle.has_second = 1'b0;
    st   = parse_state;
    skip = 1'b0;
    offn = byte_offset + 2'd1;

    if (kind == lmrp_pkg::ITEM_RESTART) begin
      parse_state_next = ST_BEGIN;
      pad_phase_next   = 1'b0;
      word_acc_next    = 32'h0;
      word_cnt_next    = 2'd0;
      log_hash_next    = 32'h0;
      log_line_next    = 16'h0;
      file_hash_next   = 32'h0;
    end else begin
      // Zero padding before a record is skipped; first nonzero byte is handed on
      if (parse_state == ST_LOG_BEGIN || parse_state == ST_FILE_BEGIN) begin
        if (data_byte == 8'h0) begin
          skip = 1'b1;
        end else if (parse_state == ST_LOG_BEGIN) begin
          st = forward_dir ? ST_LOG_STRING : ST_LOG_HASH;
        end else begin
          st = forward_dir ? ST_FILE_HASH : ST_FILE_NAME;
        end
      end
      byte_offset_next = offn;

      if (!skip) begin
        parse_state_next = st;
        unique case (st)
          ST_BEGIN: begin
            if (done2) begin
              word_acc_next = 32'h0;
              word_cnt_next = 2'd0;
              if (hit_any) begin
                parse_state_next = open_state;
                forward_dir_next = open_fwd;
              end
            end else begin
              word_acc_next = word_or;
              word_cnt_next = word_cnt + 2'd1;
            end
          end
          ST_LOG_STRING: begin
            if (pad_phase) begin
              pad_phase_next = 1'b0;
              if (!forward_dir) begin
                parse_state_next = ST_LOG_END;
                bundle.first = lmrp_pkg::make_result(lmrp_pkg::KIND_LOG_REC, 8'h0,
                                                     log_hash, log_line);
                n_res = 2'd1;
              end else begin
                parse_state_next = ST_LOG_LINE;
              end
            end else begin
              bundle.first = lmrp_pkg::make_result(lmrp_pkg::KIND_LOG_TEXT, data_byte,
                                                   32'h0, 16'h0);
              n_res = 2'd1;
              if (data_byte == 8'h0) begin
                if (offn[0]) begin
                  pad_phase_next = 1'b1;
                end else begin
                  pad_phase_next = 1'b0;
                  if (!forward_dir) begin
                    parse_state_next = ST_LOG_END;
                    n_res = 2'd2;
                  end else begin
                    parse_state_next = ST_LOG_LINE;
                  end
                end
              end
            end
          end
          ST_LOG_LINE: begin
            if (pad_phase) begin
              if (offn == 2'd0) begin
                pad_phase_next   = 1'b0;
                parse_state_next = forward_dir ? ST_LOG_HASH : ST_LOG_STRING;
              end
            end else if (done2) begin
              word_acc_next = 32'h0;
              word_cnt_next = 2'd0;
              if (word_or != 32'h0) begin
                log_line_next = word_or[15:0];
                if (offn != 2'd0) begin
                  pad_phase_next = 1'b1;
                end else begin
                  pad_phase_next   = 1'b0;
                  parse_state_next = forward_dir ? ST_LOG_HASH : ST_LOG_STRING;
                end
              end
            end else begin
              word_acc_next = word_or;
              word_cnt_next = word_cnt + 2'd1;
            end
          end
          ST_LOG_HASH: begin
            if (done4) begin
              word_acc_next = 32'h0;
              word_cnt_next = 2'd0;
              if (word_or != 32'h0) begin
                log_hash_next = word_or;
                if (forward_dir) begin
                  parse_state_next = ST_LOG_END;
                  bundle.first = lmrp_pkg::make_result(lmrp_pkg::KIND_LOG_REC, 8'h0,
                                                       word_or, log_line);
                  n_res = 2'd1;
                end else begin
                  parse_state_next = ST_LOG_STRING;
                end
              end
            end else begin
              word_acc_next = word_or;
              word_cnt_next = word_cnt + 2'd1;
            end
          end
          ST_LOG_END: begin
            // Waits here until a known token shows up
            if (done2) begin
              word_acc_next = 32'h0;
              word_cnt_next = 2'd0;
              if (hit_any) parse_state_next = ST_BEGIN;
            end else begin
              word_acc_next = word_or;
              word_cnt_next = word_cnt + 2'd1;
            end
          end
          ST_FILE_NAME: begin
            if (pad_phase) begin
              if (offn == 2'd0) begin
                pad_phase_next = 1'b0;
                if (forward_dir) begin
                  parse_state_next = ST_FILE_END;
                  bundle.first = lmrp_pkg::make_result(lmrp_pkg::KIND_FILE_REC, 8'h0,
                                                       file_hash, 16'h0);
                  n_res = 2'd1;
                end else begin
                  parse_state_next = ST_FILE_HASH;
                end
              end
            end else begin
              bundle.first = lmrp_pkg::make_result(lmrp_pkg::KIND_FILE_TEXT, data_byte,
                                                   32'h0, 16'h0);
              n_res = 2'd1;
              if (data_byte == 8'h0) begin
                if (offn != 2'd0) begin
                  pad_phase_next = 1'b1;
                end else begin
                  pad_phase_next = 1'b0;
                  if (forward_dir) begin
                    parse_state_next = ST_FILE_END;
                    bundle.second = lmrp_pkg::make_result(lmrp_pkg::KIND_FILE_REC, 8'h0,
                                                          file_hash, 16'h0);
                    n_res = 2'd2;
                  end else begin
                    parse_state_next = ST_FILE_HASH;
                  end
                end
              end
            end
          end
          ST_FILE_HASH: begin
            if (done4) begin
              word_acc_next = 32'h0;
              word_cnt_next = 2'd0;
              if (word_or != 32'h0) begin
                file_hash_next = word_or;
                if (forward_dir) begin
                  parse_state_next = ST_FILE_NAME;
                end else begin
                  parse_state_next = ST_FILE_END;
                  bundle.first = lmrp_pkg::make_result(lmrp_pkg::KIND_FILE_REC, 8'h0,
                                                       word_or, 16'h0);
                  n_res = 2'd1;
                end
              end
            end else begin
              word_acc_next = word_or;
              word_cnt_next = word_cnt + 2'd1;
            end
          end
          ST_FILE_END: begin
            // Known token opens the next block, anything else drops to begin
            if (done2) begin
              word_acc_next = 32'h0;
              word_cnt_next = 2'd0;
              if (hit_any) begin
                parse_state_next = open_state;
                forward_dir_next = open_fwd;
              end else begin
                parse_state_next = ST_BEGIN;
              end
            end else begin
              word_acc_next = word_or;
              word_cnt_next = word_cnt + 2'd1;
            end
          end
          default: parse_state_next = ST_BEGIN;
        endcase
      end
    end
    bundle.has_second = (n_res == 2'd2);
  end

  assign push = accept && (n_res != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      log_start_token  <= lmrp_pkg::RST_LOG_START;
      log_end_token    <= lmrp_pkg::RST_LOG_END;
      file_start_token <= lmrp_pkg::RST_FILE_START;
      file_end_token   <= lmrp_pkg::RST_FILE_END;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lmrp_pkg::CFG_LOG_START:  log_start_token  <= cfg_data;
        lmrp_pkg::CFG_LOG_END:    log_end_token    <= cfg_data;
        lmrp_pkg::CFG_FILE_START: file_start_token <= cfg_data;
        lmrp_pkg::CFG_FILE_END:   file_end_token   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= ST_BEGIN;
      forward_dir <= 1'b0;
      byte_offset <= 2'd0;
      pad_phase   <= 1'b0;
      word_acc    <= 32'h0;
      word_cnt    <= 2'd0;
      log_hash    <= 32'h0;
      log_line    <= 16'h0;
      file_hash   <= 32'h0;
    end else if (accept) begin
      parse_state <= parse_state_next;
      forward_dir <= forward_dir_next;
      byte_offset <= byte_offset_next;
      pad_phase   <= pad_phase_next;
      word_acc    <= word_acc_next;
      word_cnt    <= word_cnt_next;
      log_hash    <= log_hash_next;
      log_line    <= log_line_next;
      file_hash   <= file_hash_next;
    end
  end

endmodule

/* rtl/core/lmrp_queue.sv */
// Short result-bundle queue between parser front end and output back end.
`timescale 1ns / 1ps

module lmrp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  lmrp_pkg::lmrp_bundle_t push_data,
  input  logic                   pop,
  output logic                   full,
  output logic                   not_empty,
  output lmrp_pkg::lmrp_bundle_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lmrp_pkg::lmrp_bundle_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/core/lmrp_back.sv */
// Back end: walks each queued bundle out one result per transfer.
`timescale 1ns / 1ps

module lmrp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  lmrp_pkg::lmrp_bundle_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             result_kind,
  output logic [7:0]             text_byte,
  output logic [31:0]            record_hash,
  output logic [15:0]            record_line,
  output logic                   last
);

  logic                   on_second;
  lmrp_pkg::lmrp_result_t cur;
  logic                   xfer;

  assign cur         = on_second ? head.second : head.first;
  assign out_valid   = head_valid;
  assign result_kind = cur.kind;
  assign text_byte   = cur.text;
  assign record_hash = cur.hash;
  assign record_line = cur.line;
  assign last        = on_second || !head.has_second;

  assign xfer = head_valid && !out_stall;
  assign pop  = xfer && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_second <= 1'b0;
    end else if (xfer) begin
      on_second <= !last;
    end
  end

endmodule

/* rtl/core/log_metadata_record_parser.sv */
// Top level of the log metadata record parser.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-------------------------------------------
// in       | into      | in_valid/in_stall   | kind, data_byte
// out      | out of    | out_valid/out_stall | result_kind, text_byte, record_hash,
//          |           |                     | record_line, last
// cfg      | into      | cfg_write           | cfg_index, cfg_data (token registers)
//
// The parser takes one byte per cycle while in_stall is low; each byte updates the state
// machine in the cycle it transfers and its results land in the queue on the next edge.
// Output is one result per cycle while out_stall is low, so a byte that yields two
// results (string terminator plus record) holds the output port until both have gone.
// in_stall rises only when the QUEUE_DEPTH-entry queue is full; out_stall
// backs up into the queue and never stops the parser directly.
// Reset (rst, synchronous) restores the default tokens and the begin state.
module log_metadata_record_parser #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_write,
  input  logic [lmrp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                      cfg_data,
  // input byte stream
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             kind,
  input  logic [7:0]                       data_byte,
  // results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       result_kind,
  output logic [7:0]                       text_byte,
  output logic [31:0]                      record_hash,
  output logic [15:0]                      record_line,
  output logic                             last
);

  logic                   accept;
  logic                   push, pop, full, not_empty;
  lmrp_pkg::lmrp_bundle_t push_data, head;

  // An input transfer happens whenever in_valid is high and the queue has room
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  // Front: parse state machine, config registers
  lmrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .kind      (kind),
    .data_byte (data_byte),
    .push      (push),
    .bundle    (push_data)
  );

  // Decoupling queue: one entry per byte that produced output
  lmrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  // Back: serializes each bundle into one or two output transfers
  lmrp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .text_byte   (text_byte),
    .record_hash (record_hash),
    .record_line (record_line),
    .last        (last)
  );

endmodule
